/* rtl/imh_pkg.sv */
// ----------------------------------------------------------------------------
// imh_pkg
// Shared widths, operation codes and status codes of the indexed min-heap.
// ----------------------------------------------------------------------------
`default_nettype none

package imh_pkg;

  // fixed field widths
  localparam int ID_W     = 11;
  localparam int MODE_W   = 2;
  localparam int IN_SC_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 12;
  localparam int ID_SPACE = 2048;

  // defaults of the top-level parameters
  localparam int CAPACITY_DEF   = 2048;
  localparam int SCORE_BITS_DEF = 32;

  // stream widths
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 1;

  // operation codes
  localparam logic [MODE_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [MODE_W-1:0] OP_EXTRACT = 2'd1;
  localparam logic [MODE_W-1:0] OP_UPDATE  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd4;

endpackage

`default_nettype wire

/* rtl/indexed_min_heap_eviction.sv */
// ----------------------------------------------------------------------------
// indexed_min_heap_eviction
// Indexed binary min-heap of cache eviction scores with insert, extract-min
// and update-score requests.
// ----------------------------------------------------------------------------
// One request is handled at a time and gives exactly one result beat. The
// heap slots (entry id and score) live in a two-read-port memory and the
// id-to-slot map with presence bits in a second memory. A request's sift
// walks the heap one level at a time (one memory read, then compare and
// write back), and the next beat is accepted only after the result has
// been taken into the output register. After reset a clearing pass over
// the 2048 map entries runs, during which in_tready stays low.
`default_nettype none

module indexed_min_heap_eviction #(
  parameter int CAPACITY   = imh_pkg::CAPACITY_DEF,
  parameter int SCORE_BITS = imh_pkg::SCORE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // request stream
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic [imh_pkg::IN_DATA_W-1:0]  in_tdata,   // entry_id[10:0], score[42:11]
  input  wire logic [imh_pkg::IN_USER_W-1:0]  in_tuser,   // mode[1:0]
  // result stream
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  output      logic [imh_pkg::OUT_DATA_W-1:0] out_tdata,  // status[2:0], out_entry[13:3],
                                                          // out_score[45:14], count[57:46]
  output      logic [imh_pkg::OUT_USER_W-1:0] out_tuser   // out_valid[0]
);
  import imh_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int HW     = ID_W + SCORE_BITS;
  localparam int PM_W   = SLOT_W + 1;
  localparam int IDX_W  = $clog2(ID_SPACE);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_DECIDE = 11'b000_0000_0100,
    S_UPD    = 11'b000_0000_1000,
    S_SU_RD  = 11'b000_0001_0000,
    S_SU_EV  = 11'b000_0010_0000,
    S_SD_RD  = 11'b000_0100_0000,
    S_SD_EV  = 11'b000_1000_0000,
    S_WB     = 11'b001_0000_0000,
    S_FIN    = 11'b010_0000_0000,
    S_SPARE  = 11'b100_0000_0000
  } state_t;

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      clr_r, clr_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [ID_W-1:0]       id_r, id_nxt;
  logic [SCORE_BITS-1:0] sc_r, sc_nxt;
  logic [ID_W-1:0]       x_id_r, x_id_nxt;
  logic [SCORE_BITS-1:0] x_sc_r, x_sc_nxt;
  logic [STATUS_W-1:0]   res_st_r, res_st_nxt;
  logic                  res_v_r, res_v_nxt;
  logic [ID_W-1:0]       res_id_r, res_id_nxt;
  logic [SCORE_BITS-1:0] res_sc_r, res_sc_nxt;

  logic                  ov_r, ov_nxt;
  logic [STATUS_W-1:0]   o_st_r, o_st_nxt;
  logic                  o_v_r, o_v_nxt;
  logic [ID_W-1:0]       o_id_r, o_id_nxt;
  logic [IN_SC_W-1:0]    o_sc_r, o_sc_nxt;
  logic [COUNT_W-1:0]    o_cnt_r, o_cnt_nxt;

  // heap memory ports
  logic                  h_we;
  logic [SLOT_W-1:0]     h_waddr, h_ra, h_rb;
  logic [HW-1:0]         h_wdata, h_da, h_db;
  // position map ports
  logic                  p_we;
  logic [IDX_W-1:0]      p_waddr, p_ra;
  logic [PM_W-1:0]       p_wdata, p_d;

  // read data fields
  logic [ID_W-1:0]       a_id, b_id;
  logic [SCORE_BITS-1:0] a_sc, b_sc;
  logic                  pm_present;
  logic [SLOT_W-1:0]     pm_pos;

  logic [63:0]           sc_in_wide, res_sc_wide, cnt_wide;
  logic [SCORE_BITS-1:0] sc_in;
  logic                  accept;
  logic                  out_free;
  logic [SLOT_W+1:0]     left_w, right_w, cnt_ext;
  logic [SLOT_W-1:0]     parent;
  logic [CNT_W-1:0]      cnt_m1;
  logic                  sel_l, sel_r;

  assign a_id       = h_da[HW-1 -: ID_W];
  assign a_sc       = h_da[SCORE_BITS-1:0];
  assign b_id       = h_db[HW-1 -: ID_W];
  assign b_sc       = h_db[SCORE_BITS-1:0];
  assign pm_present = p_d[PM_W-1];
  assign pm_pos     = p_d[SLOT_W-1:0];

  // input score cut or padded to the stored width
  assign sc_in_wide  = 64'(in_tdata[ID_W +: IN_SC_W]);
  assign sc_in       = sc_in_wide[SCORE_BITS-1:0];
  assign res_sc_wide = 64'(res_sc_r);
  assign cnt_wide    = 64'(count_r);

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !ov_r || out_tready;

  // tree navigation
  assign left_w  = {1'b0, slot_r, 1'b1};
  assign right_w = left_w + 1'b1;
  assign cnt_ext = (SLOT_W + 2)'(count_r);
  assign parent  = (slot_r - 1'b1) >> 1;
  assign cnt_m1  = count_r - 1'b1;

  // sift-down child choice, left wins ties
  always_comb begin
    sel_l = (a_sc < x_sc_r);
    sel_r = (right_w < cnt_ext) && (b_sc < (sel_l ? a_sc : x_sc_r));
  end

  // read addresses
  always_comb begin
    h_ra = '0;
    h_rb = '0;
    p_ra = in_tdata[ID_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        h_ra = '0;
        h_rb = cnt_m1[SLOT_W-1:0];
      end
      S_DECIDE: h_ra = pm_pos;
      S_SU_RD:  h_ra = parent;
      S_SD_RD: begin
        h_ra = left_w[SLOT_W-1:0];
        h_rb = right_w[SLOT_W-1:0];
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    count_nxt  = count_r;
    slot_nxt   = slot_r;
    mode_nxt   = mode_r;
    id_nxt     = id_r;
    sc_nxt     = sc_r;
    x_id_nxt   = x_id_r;
    x_sc_nxt   = x_sc_r;
    res_st_nxt = res_st_r;
    res_v_nxt  = res_v_r;
    res_id_nxt = res_id_r;
    res_sc_nxt = res_sc_r;
    ov_nxt     = ov_r;
    o_st_nxt   = o_st_r;
    o_v_nxt    = o_v_r;
    o_id_nxt   = o_id_r;
    o_sc_nxt   = o_sc_r;
    o_cnt_nxt  = o_cnt_r;
    h_we       = 1'b0;
    h_waddr    = slot_r;
    h_wdata    = h_da;
    p_we       = 1'b0;
    p_waddr    = a_id;
    p_wdata    = {1'b1, slot_r};

    // output register drains
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_r;
        p_wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IDX_W'(ID_SPACE - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          mode_nxt   = in_tuser[MODE_W-1:0];
          id_nxt     = in_tdata[ID_W-1:0];
          sc_nxt     = sc_in;
          res_st_nxt = ST_OK;
          res_v_nxt  = 1'b0;
          res_id_nxt = '0;
          res_sc_nxt = '0;
          state_nxt  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        x_id_nxt = id_r;
        x_sc_nxt = sc_r;
        priority if (mode_r == OP_INSERT) begin
          priority if (pm_present) begin
            res_st_nxt = ST_PRESENT;
            state_nxt  = S_FIN;
          end else if (count_r == CNT_W'(CAPACITY)) begin
            res_st_nxt = ST_FULL;
            state_nxt  = S_FIN;
          end else begin
            slot_nxt  = count_r[SLOT_W-1:0];
            count_nxt = count_r + 1'b1;
            state_nxt = S_SU_RD;
          end
        end else if (mode_r == OP_EXTRACT) begin
          if (count_r == '0) begin
            res_st_nxt = ST_EMPTY;
            state_nxt  = S_FIN;
          end else begin
            res_v_nxt  = 1'b1;
            res_id_nxt = a_id;
            res_sc_nxt = a_sc;
            // drop the removed id from the map
            p_we       = 1'b1;
            p_waddr    = a_id;
            p_wdata    = '0;
            count_nxt  = cnt_m1;
            x_id_nxt   = b_id;
            x_sc_nxt   = b_sc;
            slot_nxt   = '0;
            state_nxt  = (cnt_m1 != '0) ? S_SD_RD : S_FIN;
          end
        end else if (mode_r == OP_UPDATE) begin
          if (!pm_present || ((SLOT_W + 2)'(pm_pos) >= cnt_ext)) begin
            res_st_nxt = ST_ABSENT;
            state_nxt  = S_FIN;
          end else begin
            slot_nxt  = pm_pos;
            state_nxt = S_UPD;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_UPD: begin
        // a lower score walks up, anything else walks down
        state_nxt = (x_sc_r < a_sc) ? S_SU_RD : S_SD_RD;
      end
      S_SU_RD: begin
        state_nxt = (slot_r == '0) ? S_WB : S_SU_EV;
      end
      S_SU_EV: begin
        if (x_sc_r < a_sc) begin
          // parent moves down into the hole
          h_we      = 1'b1;
          h_waddr   = slot_r;
          h_wdata   = h_da;
          p_we      = 1'b1;
          p_waddr   = a_id;
          p_wdata   = {1'b1, slot_r};
          slot_nxt  = parent;
          state_nxt = S_SU_RD;
        end else begin
          state_nxt = S_WB;
        end
      end
      S_SD_RD: begin
        state_nxt = (left_w >= cnt_ext) ? S_WB : S_SD_EV;
      end
      S_SD_EV: begin
        if (sel_r) begin
          h_we      = 1'b1;
          h_wdata   = h_db;
          p_we      = 1'b1;
          p_waddr   = b_id;
          slot_nxt  = right_w[SLOT_W-1:0];
          state_nxt = S_SD_RD;
        end else if (sel_l) begin
          h_we      = 1'b1;
          h_wdata   = h_da;
          p_we      = 1'b1;
          p_waddr   = a_id;
          slot_nxt  = left_w[SLOT_W-1:0];
          state_nxt = S_SD_RD;
        end else begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        // moving entry settles in the hole
        h_we      = 1'b1;
        h_wdata   = {x_id_r, x_sc_r};
        p_we      = 1'b1;
        p_waddr   = x_id_r;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          o_st_nxt  = res_st_r;
          o_v_nxt   = res_v_r;
          o_id_nxt  = res_id_r;
          o_sc_nxt  = res_sc_wide[IN_SC_W-1:0];
          o_cnt_nxt = cnt_wide[COUNT_W-1:0];
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    slot_r   <= slot_nxt;
    mode_r   <= mode_nxt;
    id_r     <= id_nxt;
    sc_r     <= sc_nxt;
    x_id_r   <= x_id_nxt;
    x_sc_r   <= x_sc_nxt;
    res_st_r <= res_st_nxt;
    res_v_r  <= res_v_nxt;
    res_id_r <= res_id_nxt;
    res_sc_r <= res_sc_nxt;
    o_st_r   <= o_st_nxt;
    o_v_r    <= o_v_nxt;
    o_id_r   <= o_id_nxt;
    o_sc_r   <= o_sc_nxt;
    o_cnt_r  <= o_cnt_nxt;
  end

  // heap slots: entry id over score
  imh_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (HW)
  ) u_heap (
    .clk     (clk),
    .we      (h_we),
    .waddr   (h_waddr),
    .wdata   (h_wdata),
    .raddr_a (h_ra),
    .rdata_a (h_da),
    .raddr_b (h_rb),
    .rdata_b (h_db)
  );

  // id to slot map with presence bit
  imh_ram #(
    .DEPTH (ID_SPACE),
    .WIDTH (PM_W)
  ) u_pmap (
    .clk     (clk),
    .we      (p_we),
    .waddr   (p_waddr),
    .wdata   (p_wdata),
    .raddr_a (p_ra),
    .rdata_a (p_d),
    .raddr_b ('0),
    .rdata_b ()
  );

  // result beat
  assign out_tvalid = ov_r;
  assign out_tdata  = {6'b0, o_cnt_r, o_sc_r, o_id_r, o_st_r};
  assign out_tuser  = o_v_r;

endmodule

`default_nettype wire

/* rtl/imh_ram.sv */
// ----------------------------------------------------------------------------
// imh_ram
// Synchronous memory, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module imh_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output      logic [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output      logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, registered
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

/* rtl/imh_checker.sv */
// ----------------------------------------------------------------------------
// imh_checker
// Port-level checks of the indexed min-heap result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module imh_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [imh_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [imh_pkg::OUT_USER_W-1:0] out_tuser
);
  import imh_pkg::*;

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed under stall");

  // a reported entry always comes with ok status
  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[2:0] == ST_OK)
    else $error("extracted entry with error status");

  // no entry reported means zero entry and score
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[45:3] == '0)
    else $error("stray entry or score");

  // empty heap reports zero count
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == ST_EMPTY |-> out_tdata[57:46] == '0 && !out_tuser[0])
    else $error("empty status with entries");

endmodule

bind indexed_min_heap_eviction imh_checker u_imh_checker (.*);

`default_nettype wire
